// ===== hdl/tfrt_pkg.sv =====
package tfrt_pkg;

  localparam int unsigned FlowEntriesDefault = 64;
  localparam int unsigned BufferBytes = 65536;

  localparam logic [7:0] TlsHandshake = 8'h16;
  localparam logic [2:0] TlsHdrLen = 3'd5;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_APPEND   = 3'd1,
    ST_SEQ_MISS = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // segment metadata as it travels from front to back
  typedef struct packed {
    logic [3:0]  ipver;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_number;
    logic [15:0] seg_len;
    logic [7:0]  header_byte0;
    logic [7:0]  header_byte3;
    logic [7:0]  header_byte4;
  } seg_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] flow_index;
    logic [16:0] write_offset;
    logic        complete;
    logic [16:0] expected_len;
  } res_t;

endpackage

// ===== hdl/tfrt_front.sv =====
// Input skid register: accepts a segment word and holds it for the table stage.
module tfrt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  tfrt_pkg::seg_t s_seg_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output tfrt_pkg::seg_t q_seg_o
);

  logic [1:0]     cnt_q, cnt_d;
  tfrt_pkg::seg_t buf_q [2];
  logic           rd_q, rd_d, wr_q, wr_d;
  logic           push, pop;

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_seg_o   = buf_q[rd_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (pop) begin
      rd_d = ~rd_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= s_seg_i;
    end
  end

endmodule

// ===== hdl/tfrt_table.sv =====
// Flow table: parallel key match, in-order append, allocation, result register.
// Look cycle: key match and registered read of the hit entry; exec cycle: decide and write back.
module tfrt_table #(
  parameter int unsigned FlowEntries = tfrt_pkg::FlowEntriesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  tfrt_pkg::seg_t q_seg_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output tfrt_pkg::res_t m_res_o
);

  localparam int unsigned IdxW = (FlowEntries > 1) ? $clog2(FlowEntries) : 1;
  localparam logic [0:0] StLook = 1'b0;
  localparam logic [0:0] StExec = 1'b1;

  logic [FlowEntries-1:0] vld_q;
  logic [3:0]   ver_q  [FlowEntries];
  logic [63:0]  addr_q [FlowEntries];
  logic [31:0]  port_q [FlowEntries];
  logic [31:0]  nseq_q [FlowEntries];
  logic [16:0]  bufl_q [FlowEntries];
  logic [16:0]  exp_q  [FlowEntries];
  logic         done_q [FlowEntries];

  logic [FlowEntries-1:0] match;
  logic            hit, fre;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic            take, exec;
  logic [0:0]      state_q, state_d;
  logic            out_v_q;
  tfrt_pkg::res_t  res_q, res_d;
  tfrt_pkg::seg_t  seg_q;
  logic            hit_q, fre_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [31:0]     nseq_rd_q;
  logic [16:0]     bufl_rd_q, exp_rd_q;
  logic            done_rd_q;
  logic [17:0]     sum;
  logic [16:0]     new_exp;
  logic            wr_alloc, wr_app;
  logic            is_tls;

  assign q_ready_o = (state_q == StLook) && (!out_v_q || m_ready_i);
  assign take      = q_valid_i && q_ready_o;
  assign exec      = (state_q == StExec);
  assign m_valid_o = out_v_q;
  assign m_res_o   = res_q;

  always_comb begin
    state_d = state_q;
    if (take) begin
      state_d = StExec;
    end else if (exec) begin
      state_d = StLook;
    end
  end

  always_comb begin
    for (int i = 0; i < FlowEntries; i++) begin
      match[i] = vld_q[i] && ver_q[i] == q_seg_i.ipver
        && addr_q[i] == {q_seg_i.src_ip, q_seg_i.dst_ip}
        && port_q[i] == {q_seg_i.sport, q_seg_i.dport};
    end
  end

  always_comb begin
    hit = 1'b0;
    fre = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = FlowEntries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!vld_q[i]) begin
        fre = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    sum = 18'(bufl_rd_q) + 18'(seg_q.seg_len);
    is_tls = seg_q.seg_len >= 16'(tfrt_pkg::TlsHdrLen)
      && seg_q.header_byte0 == tfrt_pkg::TlsHandshake;
    new_exp = is_tls ? 17'({seg_q.header_byte3, seg_q.header_byte4})
      + 17'(tfrt_pkg::TlsHdrLen) : 17'd0;
    wr_alloc = 1'b0;
    wr_app = 1'b0;
    res_d = '0;
    if (hit_q) begin
      res_d.flow_index   = 16'(hit_idx_q);
      res_d.write_offset = bufl_rd_q;
      res_d.complete     = done_rd_q;
      res_d.expected_len = exp_rd_q;
      if (nseq_rd_q != seg_q.seq_number) begin
        res_d.status = tfrt_pkg::ST_SEQ_MISS;
      end else if (sum > 18'(tfrt_pkg::BufferBytes)) begin
        res_d.status = tfrt_pkg::ST_OVERFLOW;
      end else begin
        res_d.status = tfrt_pkg::ST_APPEND;
        wr_app = 1'b1;
        res_d.complete = done_rd_q
          || (exp_rd_q != 17'd0 && 18'(exp_rd_q) == sum);
      end
    end else if (!fre_q) begin
      res_d.status = tfrt_pkg::ST_FULL;
    end else begin
      res_d.flow_index = 16'(free_idx_q);
      if (32'(seg_q.seg_len) > 32'(tfrt_pkg::BufferBytes)) begin
        res_d.status = tfrt_pkg::ST_OVERFLOW;
      end else begin
        res_d.status = tfrt_pkg::ST_NEW;
        wr_alloc = 1'b1;
        res_d.expected_len = new_exp;
        res_d.complete = is_tls && new_exp == 17'(seg_q.seg_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
      state_q <= StLook;
    end else begin
      state_q <= state_d;
      if (exec) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (exec && wr_alloc) begin
        vld_q[free_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      seg_q      <= q_seg_i;
      hit_q      <= hit;
      fre_q      <= fre;
      hit_idx_q  <= hit_idx;
      free_idx_q <= free_idx;
      nseq_rd_q  <= nseq_q[hit_idx];
      bufl_rd_q  <= bufl_q[hit_idx];
      exp_rd_q   <= exp_q[hit_idx];
      done_rd_q  <= done_q[hit_idx];
    end
    if (exec) begin
      res_q <= res_d;
    end
    if (exec && wr_alloc) begin
      ver_q[free_idx_q]  <= seg_q.ipver;
      addr_q[free_idx_q] <= {seg_q.src_ip, seg_q.dst_ip};
      port_q[free_idx_q] <= {seg_q.sport, seg_q.dport};
      nseq_q[free_idx_q] <= seg_q.seq_number + 32'(seg_q.seg_len);
      bufl_q[free_idx_q] <= 17'(seg_q.seg_len);
      exp_q[free_idx_q]  <= new_exp;
      done_q[free_idx_q] <= res_d.complete;
    end
    if (exec && wr_app) begin
      nseq_q[hit_idx_q] <= seg_q.seq_number + 32'(seg_q.seg_len);
      bufl_q[hit_idx_q] <= sum[16:0];
      done_q[hit_idx_q] <= res_d.complete;
    end
  end

endmodule

// ===== hdl/tcp_flow_reassembly_tracker.sv =====
// TCP flow reassembly tracker. Each segment word carries a flow key, a sequence
// number, a length and three payload header bytes; each yields exactly one
// result word with status, table entry, write offset, completion and expected
// length. A two-entry input queue feeds the flow table stage. The table takes
// each segment through a look state, which matches the key against all entries
// at once and reads the hit entry's state into registers, and an exec state,
// which decides, writes back and registers the result. It takes no new segment
// until the last one has been decided; a result held by the sink stalls the
// table. Entries are never freed.
module tcp_flow_reassembly_tracker #(
  parameter int unsigned FlowEntries = tfrt_pkg::FlowEntriesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ipver, src_ip, dst_ip, sport, dport, seq_number, seg_len,
  // header_byte0, header_byte3, header_byte4
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, flow_index, write_offset, complete, expected_len
  output logic [47:0]  m_axis_tdata
);

  tfrt_pkg::seg_t seg, qseg;
  tfrt_pkg::res_t res;
  logic           qv, qr;

  assign seg.ipver        = s_axis_tdata[3:0];
  assign seg.src_ip       = s_axis_tdata[35:4];
  assign seg.dst_ip       = s_axis_tdata[67:36];
  assign seg.sport        = s_axis_tdata[83:68];
  assign seg.dport        = s_axis_tdata[99:84];
  assign seg.seq_number   = s_axis_tdata[131:100];
  assign seg.seg_len      = s_axis_tdata[147:132];
  assign seg.header_byte0 = s_axis_tdata[155:148];
  assign seg.header_byte3 = s_axis_tdata[163:156];
  assign seg.header_byte4 = s_axis_tdata[171:164];

  tfrt_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_seg_i(seg),
    .q_valid_o(qv), .q_ready_i(qr), .q_seg_o(qseg)
  );

  tfrt_table #(.FlowEntries(FlowEntries)) u_table (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_seg_i(qseg),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_res_o(res)
  );

  assign m_axis_tdata = {4'd0, res.expected_len, res.complete, res.write_offset,
                         res.flow_index[5:0], res.status};

endmodule
